@@ hdl/ecpp_pkg.sv @@
// ----------------------------------------------------------------------------
// ecpp_pkg
// Shared widths and fixed-point constants of the escape count palette.
// ----------------------------------------------------------------------------
package ecpp_pkg;

  // width of an escape count's magnitude and of the running maximum
  localparam int COUNT_BITS = 16;

  // fraction bits of t = count / max (Q1.16)
  localparam int FRAC_BITS = 16;
  localparam int FIX_W     = FRAC_BITS + 1;
  localparam int PROD_W    = 2 * FIX_W;
  localparam int ITER_W    = $clog2(FRAC_BITS);

  localparam logic [FIX_W-1:0] ONE_Q16 = FIX_W'(1) << FRAC_BITS;

  // channel gains: 9*255, 15*255, 8.5*255 (blue gets one more shift)
  localparam logic [FIX_W-1:0] K_RED   = FIX_W'(2295);
  localparam logic [FIX_W-1:0] K_GREEN = FIX_W'(3825);
  localparam logic [FIX_W-1:0] K_BLUE  = FIX_W'(4335);

endpackage

@@ hdl/ecpp_count_if.sv @@
// ----------------------------------------------------------------------------
// ecpp_count_if
// Request channel of escape counts: opcode, count and frame start flag.
// ----------------------------------------------------------------------------
interface ecpp_count_if;
  import ecpp_pkg::*;

  logic                    valid;
  logic                    ready;
  logic                    opcode;
  logic signed [COUNT_BITS:0] escape_count;
  logic                    frame_start;

  modport source (output valid, opcode, escape_count, frame_start, input ready);
  modport sink   (input valid, opcode, escape_count, frame_start, output ready);

endinterface

@@ hdl/ecpp_color_if.sv @@
// ----------------------------------------------------------------------------
// ecpp_color_if
// Result channel carrying one RGB pixel colour.
// ----------------------------------------------------------------------------
interface ecpp_color_if;

  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;

  modport source (output valid, red, green, blue, input ready);
  modport sink   (input valid, red, green, blue, output ready);

endinterface

@@ hdl/escape_count_polynomial_palette.sv @@
// ----------------------------------------------------------------------------
// escape_count_polynomial_palette
// Colours fractal escape counts with a Bernstein polynomial palette. A scan
// request (opcode 0) folds its count into a running maximum, cleared first
// when frame_start is set. A map request (opcode 1) returns one colour:
// t = count/max in Q1.16, r = 9(1-t)t^3, g = 15(1-t)^2t^2, b = 8.5(1-t)^3t,
// each times 255 and saturated. A negative count or an empty maximum gives
// black; a count at or above the maximum sets t to one directly; any other
// count first runs a 16-step restoring divider. Both then run 10 products
// through one shared 17x17 multiplier. A finished colour sits in an output
// register, so the next request is taken while it waits; a new colour waits
// only if that register is still full.
// ----------------------------------------------------------------------------
module escape_count_polynomial_palette (
  input  logic                clk,
  input  logic                rst,
  ecpp_count_if.sink          count,
  ecpp_color_if.source        color
);
  import ecpp_pkg::*;

  // ---------------------------------------------------------------- microcode
  localparam int PC_W = 4;

  localparam logic [PC_W-1:0] S_ACCEPT = PC_W'(0);
  localparam logic [PC_W-1:0] S_BLACK  = PC_W'(1);
  localparam logic [PC_W-1:0] S_SAT    = PC_W'(2);
  localparam logic [PC_W-1:0] S_DIV    = PC_W'(3);
  localparam logic [PC_W-1:0] S_INV    = PC_W'(4);
  localparam logic [PC_W-1:0] S_T2     = PC_W'(5);
  localparam logic [PC_W-1:0] S_T3     = PC_W'(6);
  localparam logic [PC_W-1:0] S_U2     = PC_W'(7);
  localparam logic [PC_W-1:0] S_U3     = PC_W'(8);
  localparam logic [PC_W-1:0] S_RX     = PC_W'(9);
  localparam logic [PC_W-1:0] S_RED    = PC_W'(10);
  localparam logic [PC_W-1:0] S_GX     = PC_W'(11);
  localparam logic [PC_W-1:0] S_GREEN  = PC_W'(12);
  localparam logic [PC_W-1:0] S_BX     = PC_W'(13);
  localparam logic [PC_W-1:0] S_BLUE   = PC_W'(14);
  localparam logic [PC_W-1:0] S_EMIT   = PC_W'(15);

  typedef enum logic [2:0] {
    OP_ACCEPT, OP_CLEAR, OP_SAT, OP_DIV, OP_INV, OP_MUL, OP_EMIT
  } op_t;

  typedef enum logic [1:0] {W_NONE, W_IN, W_OUT} wait_t;

  typedef enum logic [2:0] {
    C_NEXT, C_ALWAYS, C_SCAN, C_BLACK, C_GE, C_ITER
  } cond_t;

  typedef enum logic [3:0] {
    SRC_T, SRC_U, SRC_T2, SRC_T3, SRC_U2, SRC_U3, SRC_X,
    SRC_KRED, SRC_KGREEN, SRC_KBLUE
  } src_t;

  typedef enum logic [3:0] {
    DST_NONE, DST_T2, DST_T3, DST_U2, DST_U3, DST_X,
    DST_RED, DST_GREEN, DST_BLUE
  } dst_t;

  typedef struct packed {
    op_t             op;
    wait_t           wt;
    cond_t           cond;
    logic [PC_W-1:0] target;
    src_t            src_a;
    src_t            src_b;
    dst_t            dst;
    logic            shr17;
  } uword_t;

  function automatic uword_t mul_word(src_t a, src_t b, dst_t d, logic s17);
    uword_t w;
    w = '{op: OP_MUL, wt: W_NONE, cond: C_NEXT, target: S_ACCEPT,
          src_a: a, src_b: b, dst: d, shr17: s17};
    return w;
  endfunction

  function automatic uword_t ctl_word(op_t op, wait_t wt, cond_t c,
                                      logic [PC_W-1:0] tgt);
    uword_t w;
    w = '{op: op, wt: wt, cond: c, target: tgt,
          src_a: SRC_T, src_b: SRC_T, dst: DST_NONE, shr17: 1'b0};
    return w;
  endfunction

  function automatic uword_t ucode(logic [PC_W-1:0] step);
    uword_t w;
    unique case (step)
      S_ACCEPT: w = ctl_word(OP_ACCEPT, W_IN,   C_SCAN,   S_ACCEPT);
      S_BLACK:  w = ctl_word(OP_CLEAR,  W_NONE, C_BLACK,  S_EMIT);
      S_SAT:    w = ctl_word(OP_SAT,    W_NONE, C_GE,     S_INV);
      S_DIV:    w = ctl_word(OP_DIV,    W_NONE, C_ITER,   S_DIV);
      S_INV:    w = ctl_word(OP_INV,    W_NONE, C_NEXT,   S_ACCEPT);
      S_T2:     w = mul_word(SRC_T,      SRC_T,  DST_T2,    1'b0);
      S_T3:     w = mul_word(SRC_T2,     SRC_T,  DST_T3,    1'b0);
      S_U2:     w = mul_word(SRC_U,      SRC_U,  DST_U2,    1'b0);
      S_U3:     w = mul_word(SRC_U2,     SRC_U,  DST_U3,    1'b0);
      S_RX:     w = mul_word(SRC_U,      SRC_T3, DST_X,     1'b0);
      S_RED:    w = mul_word(SRC_KRED,   SRC_X,  DST_RED,   1'b0);
      S_GX:     w = mul_word(SRC_U2,     SRC_T2, DST_X,     1'b0);
      S_GREEN:  w = mul_word(SRC_KGREEN, SRC_X,  DST_GREEN, 1'b0);
      S_BX:     w = mul_word(SRC_U3,     SRC_T,  DST_X,     1'b0);
      S_BLUE:   w = mul_word(SRC_KBLUE,  SRC_X,  DST_BLUE,  1'b1);
      S_EMIT:   w = ctl_word(OP_EMIT,   W_OUT,  C_ALWAYS, S_ACCEPT);
    endcase
    return w;
  endfunction

  // ---------------------------------------------------------------- registers
  logic [PC_W-1:0]       pc;
  logic [COUNT_BITS-1:0] max_count;
  logic [COUNT_BITS-1:0] cnt;
  logic                  neg;
  logic [COUNT_BITS-1:0] rem;
  logic [ITER_W-1:0]     iter;
  logic [FIX_W-1:0]      t, u, t2, t3, u2, u3, x;
  logic [7:0]            px_red, px_green, px_blue;
  logic                  out_valid;
  logic [7:0]            out_red, out_green, out_blue;

  uword_t ctl;
  logic   stall, take, count_acc, black, ge;

  assign ctl       = ucode(pc);
  assign count.ready = (ctl.wt == W_IN) && !rst;
  assign count_acc = count.valid && count.ready;
  assign black     = neg || (max_count == '0);
  assign ge        = (cnt >= max_count);
  assign stall     = ((ctl.wt == W_IN) && !count.valid) ||
                     ((ctl.wt == W_OUT) && out_valid && !color.ready);

  always_comb begin
    unique case (ctl.cond)
      C_NEXT:   take = 1'b0;
      C_ALWAYS: take = 1'b1;
      C_SCAN:   take = !count.opcode;
      C_BLACK:  take = black;
      C_GE:     take = ge;
      C_ITER:   take = (iter != '0);
      default:  take = 1'b0;
    endcase
  end

  // ------------------------------------------------------- shared multiplier
  function automatic logic [FIX_W-1:0] operand(src_t s, logic [FIX_W-1:0] vt,
      logic [FIX_W-1:0] vu, logic [FIX_W-1:0] vt2, logic [FIX_W-1:0] vt3,
      logic [FIX_W-1:0] vu2, logic [FIX_W-1:0] vu3, logic [FIX_W-1:0] vx);
    logic [FIX_W-1:0] r;
    unique case (s)
      SRC_T:      r = vt;
      SRC_U:      r = vu;
      SRC_T2:     r = vt2;
      SRC_T3:     r = vt3;
      SRC_U2:     r = vu2;
      SRC_U3:     r = vu3;
      SRC_X:      r = vx;
      SRC_KRED:   r = K_RED;
      SRC_KGREEN: r = K_GREEN;
      SRC_KBLUE:  r = K_BLUE;
      default:    r = '0;
    endcase
    return r;
  endfunction

  logic [FIX_W-1:0]  mul_a, mul_b, mul_res;
  logic [PROD_W-1:0] prod;
  logic [7:0]        mul_sat;

  assign mul_a   = operand(ctl.src_a, t, u, t2, t3, u2, u3, x);
  assign mul_b   = operand(ctl.src_b, t, u, t2, t3, u2, u3, x);
  assign prod    = PROD_W'(mul_a) * PROD_W'(mul_b);
  assign mul_res = ctl.shr17 ? prod[FRAC_BITS+FIX_W:FRAC_BITS+1]
                             : prod[FRAC_BITS+FIX_W-1:FRAC_BITS];
  assign mul_sat = (mul_res > FIX_W'(255)) ? 8'hFF : mul_res[7:0];

  // ---------------------------------------------------------- divider step
  logic [COUNT_BITS:0]   shifted;
  logic [COUNT_BITS+1:0] diff;
  logic                  qbit;

  assign shifted = {rem, 1'b0};
  assign diff    = {1'b0, shifted} - {2'b00, max_count};
  assign qbit    = !diff[COUNT_BITS+1];

  // ------------------------------------------------------------- scan update
  logic [COUNT_BITS-1:0] scan_base, max_next;
  logic                  in_neg;
  logic [COUNT_BITS-1:0] in_cnt;

  assign in_neg    = count.escape_count[COUNT_BITS];
  assign in_cnt    = count.escape_count[COUNT_BITS-1:0];
  assign scan_base = count.frame_start ? '0 : max_count;
  assign max_next  = (!in_neg && (in_cnt > scan_base)) ? in_cnt : scan_base;

  // --------------------------------------------------------------- control
  always_ff @(posedge clk) begin
    if (rst) begin
      pc        <= S_ACCEPT;
      max_count <= '0;
      out_valid <= 1'b0;
    end else begin
      // a new colour keeps the register full, else a taken colour empties it
      if (!stall && ctl.op == OP_EMIT) begin
        out_valid <= 1'b1;
      end else if (color.ready) begin
        out_valid <= 1'b0;
      end
      if (!stall) begin
        pc <= take ? ctl.target : pc + PC_W'(1);
        if (ctl.op == OP_ACCEPT && count_acc && !count.opcode) begin
          max_count <= max_next;
        end
      end
    end
  end

  // --------------------------------------------------------------- datapath
  always_ff @(posedge clk) begin
    if (!stall) begin
      unique case (ctl.op)
        OP_ACCEPT: begin
          cnt <= in_cnt;
          neg <= in_neg;
        end
        OP_CLEAR: begin
          px_red   <= '0;
          px_green <= '0;
          px_blue  <= '0;
        end
        OP_SAT: begin
          t    <= ONE_Q16;
          rem  <= cnt;
          iter <= ITER_W'(FRAC_BITS - 1);
        end
        OP_DIV: begin
          rem  <= qbit ? diff[COUNT_BITS-1:0] : shifted[COUNT_BITS-1:0];
          t    <= {t[FIX_W-2:0], qbit};
          iter <= iter - ITER_W'(1);
        end
        OP_INV: begin
          u <= ONE_Q16 - t;
        end
        OP_MUL: begin
          unique case (ctl.dst)
            DST_T2:    t2       <= mul_res;
            DST_T3:    t3       <= mul_res;
            DST_U2:    u2       <= mul_res;
            DST_U3:    u3       <= mul_res;
            DST_X:     x        <= mul_res;
            DST_RED:   px_red   <= mul_sat;
            DST_GREEN: px_green <= mul_sat;
            DST_BLUE:  px_blue  <= mul_sat;
            default: ;
          endcase
        end
        OP_EMIT: begin
          out_red   <= px_red;
          out_green <= px_green;
          out_blue  <= px_blue;
        end
        default: ;
      endcase
    end
  end

  assign color.valid = out_valid;
  assign color.red   = out_red;
  assign color.green = out_green;
  assign color.blue  = out_blue;

`ifndef ASSERT_OFF
  // remainder stays below the divisor throughout the divide loop
  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    (ctl.op == OP_DIV) |-> (rem < max_count))
    else $error("divider remainder not below maximum");

  // t is a fraction in [0, 1]
  a_t_range: assert property (@(posedge clk) disable iff (rst)
    (pc == S_INV) |-> (t <= ONE_Q16))
    else $error("t above one");

  // a scan request without frame start never lowers the maximum
  a_max_mono: assert property (@(posedge clk) disable iff (rst)
    (count_acc && !count.opcode && !count.frame_start)
      |=> (max_count >= $past(max_count)))
    else $error("maximum decreased");

  // the maximum holds still while a map request is worked on
  a_max_hold: assert property (@(posedge clk) disable iff (rst)
    (pc != S_ACCEPT) |=> $stable(max_count))
    else $error("maximum changed during map");

  // a colour is presented right after the emit step runs
  a_emit: assert property (@(posedge clk) disable iff (rst)
    (ctl.op == OP_EMIT && !stall) |=> color.valid)
    else $error("emitted colour not valid");
`endif

endmodule
